// ===== src/diamond_max_path_sum_assert.svh =====
// Assertion macros shared by the diamond path sum RTL.
`ifndef DIAMOND_MAX_PATH_SUM_ASSERT_SVH
`define DIAMOND_MAX_PATH_SUM_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and held off during reset.
`define DMPS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("diamond_max_path_sum: same-cycle check failed");

// Next-cycle implication, sampled on clk_i and held off during reset.
`define DMPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("diamond_max_path_sum: next-cycle check failed");

`endif

// ===== src/dmps_pkg.sv =====
// Shared constants and types of the diamond grid path sum block.
package dmps_pkg;

  localparam int MaxSize  = 128;
  localparam int CellBits = 16;
  localparam int ValW     = 16;
  localparam int SumW     = 23;
  localparam int CfgW     = 8;
  localparam int DataW    = 32;
  localparam int AddrW    = 3;
  localparam int IdxW     = $clog2(MaxSize);
  localparam int CntW     = $clog2(MaxSize + 1);
  localparam int RowW     = $clog2(2 * MaxSize - 1);

  // Register index as decoded from paddr[2].
  localparam logic RegGridSize = 1'b0;

  // How far the row queue moves toward its head in one transfer.
  typedef enum logic [1:0] {
    ShNone = 2'd0,
    ShOne  = 2'd1,
    ShTwo  = 2'd2
  } shift_e;

  typedef struct packed {
    logic   en;
    shift_e shift;
  } cell_ctl_t;

  typedef struct packed {
    cell_ctl_t       op;
    logic [IdxW-1:0] tail;
  } queue_ctl_t;

endpackage

// ===== src/dmps_cell.sv =====
// One storage cell of the row queue: holds one best path sum.
module dmps_cell (
  input  logic                     clk_i,
  input  dmps_pkg::cell_ctl_t      ctl_i,
  input  logic                     hit_i,
  input  logic [dmps_pkg::SumW-1:0] next1_i,
  input  logic [dmps_pkg::SumW-1:0] next2_i,
  input  logic [dmps_pkg::SumW-1:0] wdata_i,
  output logic [dmps_pkg::SumW-1:0] value_o
);
  import dmps_pkg::*;

  logic [SumW-1:0] value_q;
  logic [SumW-1:0] value_d;

  always_comb begin
    value_d = value_q;
    if (hit_i) begin
      value_d = wdata_i;
    end else begin
      case (ctl_i.shift)
        ShNone:  value_d = value_q;
        ShOne:   value_d = next1_i;
        ShTwo:   value_d = next2_i;
        default: value_d = value_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      value_q <= value_d;
    end
  end

  assign value_o = value_q;

endmodule

// ===== src/dmps_chain.sv =====
// Row queue built as a chain of cells that shift toward the head.
module dmps_chain (
  input  logic                      clk_i,
  input  dmps_pkg::queue_ctl_t      ctl_i,
  input  logic [dmps_pkg::SumW-1:0] wdata_i,
  output logic [dmps_pkg::SumW-1:0] head_o,
  output logic [dmps_pkg::SumW-1:0] second_o
);
  import dmps_pkg::*;

  logic [SumW-1:0] vals [MaxSize];

  for (genvar k = 0; k < MaxSize; k++) begin : g_cell
    logic            hit;
    logic [SumW-1:0] nxt1;
    logic [SumW-1:0] nxt2;

    assign hit = ctl_i.op.en && (ctl_i.tail == IdxW'(k));

    if (k + 1 < MaxSize) begin : g_n1
      assign nxt1 = vals[k+1];
    end else begin : g_n1z
      assign nxt1 = '0;
    end

    if (k + 2 < MaxSize) begin : g_n2
      assign nxt2 = vals[k+2];
    end else begin : g_n2z
      assign nxt2 = '0;
    end

    dmps_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl_i.op),
      .hit_i   (hit),
      .next1_i (nxt1),
      .next2_i (nxt2),
      .wdata_i (wdata_i),
      .value_o (vals[k])
    );
  end

  assign head_o = vals[0];

  if (MaxSize > 1) begin : g_sec
    assign second_o = vals[1];
  end else begin : g_secz
    assign second_o = '0;
  end

endmodule

// ===== src/diamond_max_path_sum.sv =====
// Top level of the diamond grid maximum path sum block.
//
// Cells of a diamond grid arrive one per transfer on the input channel
// (cell_value_i with in_valid_i / in_stall_o), row by row: rows of 1, 2, ...
// N cells, then N-1 down to 1, where N is the grid_size register written over
// the APB-style port (byte address 0, reset value 1; 0 acts as 1).
// A cell is accepted at a rising edge with in_valid_i high and in_stall_o low.
// Unless in_stall_o holds it off, the block takes one cell per clock cycle with
// no bubbles: a cell's whole update is one add and one compare against the head
// of the row queue. After a grid's last cell, its largest top-to-bottom path sum
// appears on max_path_sum_o with out_valid_o in the next cycle and stays
// until a transfer with out_stall_i low. While that result waits, cells of the
// next grid keep flowing in; only its last cell is held off by in_stall_o.
// Reset empties the row queue, returns to the top cell and drops any pending
// result. Writing grid_size abandons a grid in progress without a result.
module diamond_max_path_sum (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dmps_pkg::AddrW-1:0]    paddr,
  input  logic [dmps_pkg::DataW-1:0]    pwdata,
  output logic [dmps_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  input  logic [dmps_pkg::ValW-1:0]     cell_value_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  output logic [dmps_pkg::SumW-1:0]     max_path_sum_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i
);
  import dmps_pkg::*;

  `include "diamond_max_path_sum_assert.svh"

  // Configuration: raw register value for readback and the clamped size.
  logic [CfgW-1:0] gs_q;
  logic [CntW-1:0] n_q, n_d;
  logic            cfg_wr;
  logic [CfgW-1:0] wval;

  // Position in the grid, queue fill level and the saved left neighbor.
  logic [RowW-1:0] row_q;
  logic [IdxW-1:0] col_q;
  logic [CntW-1:0] cnt_q;
  logic [SumW-1:0] left_q;

  logic [SumW-1:0] res_q;
  logic            res_vld_q;

  logic            acc;
  logic            upper, row0, has_left, has_same;
  logic [CntW-1:0] row_len;
  logic            last_col, grid_end;
  logic [SumW-1:0] head, second, best, sum_sat;
  logic [SumW:0]   sum_full;
  logic [CntW-1:0] sh_amt;
  shift_e          shift;
  queue_ctl_t      qctl;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegGridSize);
  assign wval   = pwdata[CfgW-1:0];
  assign prdata = (paddr[2] == RegGridSize) ? DataW'(gs_q) : '0;

  // A size of zero behaves as one; a size beyond the queue depth is clamped.
  always_comb begin
    if (wval == '0) begin
      n_d = CntW'(1);
    end else if (32'(wval) > 32'(MaxSize)) begin
      n_d = CntW'(MaxSize);
    end else begin
      n_d = CntW'(wval);
    end
  end

  // Row shape. Upper rows grow by one cell, lower rows shrink by one.
  assign row0  = (row_q == '0);
  assign upper = ((RowW+1)'(row_q) < (RowW+1)'(n_q));
  assign row_len = upper ? CntW'((RowW+1)'(row_q) + 1'b1)
                         : CntW'(((RowW+1)'(n_q) << 1) - 1'b1 - (RowW+1)'(row_q));
  assign last_col = ((CntW'(col_q) + 1'b1) == row_len);
  assign grid_end = last_col &&
                    ((RowW+1)'(row_q) == (((RowW+1)'(n_q) << 1) - (RowW+1)'(2)));

  // Only the cell that closes a grid needs room in the result register.
  assign in_stall_o = res_vld_q && out_stall_i && grid_end;
  assign acc        = in_valid_i && !in_stall_o;

  // The queue head holds the previous row's entry at this column and the next
  // cell holds the one to its right; new sums are appended at the tail.
  assign has_left = (col_q != '0);
  assign has_same = ((RowW+1)'(col_q) < (RowW+1)'(row_q));

  always_comb begin
    best  = '0;
    shift = ShNone;
    if (row0) begin
      best  = '0;
      shift = ShNone;
    end else if (upper) begin
      if (has_left && has_same) begin
        best = (left_q > head) ? left_q : head;
      end else if (has_left) begin
        best = left_q;
      end else begin
        best = head;
      end
      shift = has_same ? ShOne : ShNone;
    end else begin
      best  = (head > second) ? head : second;
      // The last cell of a lower row also drops the previous row's last entry.
      shift = last_col ? ShTwo : ShOne;
    end
  end

  always_comb begin
    case (shift)
      ShNone:  sh_amt = CntW'(0);
      ShOne:   sh_amt = CntW'(1);
      ShTwo:   sh_amt = CntW'(2);
      default: sh_amt = CntW'(0);
    endcase
  end

  assign sum_full = (SumW+1)'(best) + (SumW+1)'(cell_value_i[CellBits-1:0]);
  assign sum_sat  = sum_full[SumW] ? {SumW{1'b1}} : sum_full[SumW-1:0];

  assign qctl.op.en    = acc;
  assign qctl.op.shift = shift;
  assign qctl.tail     = IdxW'(cnt_q - sh_amt);

  dmps_chain u_chain (
    .clk_i    (clk_i),
    .ctl_i    (qctl),
    .wdata_i  (sum_sat),
    .head_o   (head),
    .second_o (second)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gs_q   <= CfgW'(1);
      n_q    <= CntW'(1);
      row_q  <= '0;
      col_q  <= '0;
      cnt_q  <= '0;
      left_q <= '0;
    end else if (cfg_wr) begin
      gs_q   <= wval;
      n_q    <= n_d;
      row_q  <= '0;
      col_q  <= '0;
      cnt_q  <= '0;
      left_q <= '0;
    end else if (acc) begin
      if (upper && !row0 && has_same) begin
        left_q <= head;
      end
      if (grid_end) begin
        row_q  <= '0;
        col_q  <= '0;
        cnt_q  <= '0;
        left_q <= '0;
      end else begin
        cnt_q <= cnt_q - sh_amt + 1'b1;
        if (last_col) begin
          col_q <= '0;
          row_q <= row_q + 1'b1;
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
    end
  end

  // Result register: loads on the closing cell, clears on an output transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (acc && grid_end) begin
      res_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && grid_end) begin
      res_q <= sum_sat;
    end
  end

  assign max_path_sum_o = res_q;
  assign out_valid_o    = res_vld_q;

  `DMPS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= n_q)
  `DMPS_ASSERT_NOW(a_col_in_row, 1'b1, CntW'(col_q) < row_len)
  `DMPS_ASSERT_NOW(a_top_empty, row0 && (col_q == '0), cnt_q == '0)
  `DMPS_ASSERT_NEXT(a_result_loaded, acc && grid_end && !cfg_wr, res_vld_q)
  `DMPS_ASSERT_NOW(a_stall_only_full, in_stall_o, res_vld_q && grid_end)

endmodule

// ===== sim/diamond_max_path_sum_check.sv =====
// Checker that predicts the diamond path sums and compares them with the block's results.
module diamond_max_path_sum_check (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dmps_pkg::AddrW-1:0]    paddr,
  input  logic [dmps_pkg::DataW-1:0]    pwdata,
  input  logic [dmps_pkg::DataW-1:0]    prdata,
  input  logic                          pready,
  input  logic [dmps_pkg::ValW-1:0]     cell_value_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_o,
  input  logic [dmps_pkg::SumW-1:0]     max_path_sum_o,
  input  logic                          out_valid_o,
  input  logic                          out_stall_i,
  output int                            fail_count,
  output int                            sums_pending
);
  import dmps_pkg::*;

  logic [SumW-1:0] best_row [MaxSize];
  logic [SumW-1:0] left_sum;
  int unsigned     row_idx;
  int unsigned     col_idx;
  logic [CfgW-1:0] grid_size;
  logic [SumW-1:0] sums_due [$];

  function automatic logic [SumW-1:0] sat_sum(input logic [SumW-1:0] a,
                                              input logic [SumW-1:0] b);
    logic [SumW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SumW] ? {SumW{1'b1}} : s[SumW-1:0];
  endfunction

  function automatic logic [SumW-1:0] larger(input logic [SumW-1:0] a,
                                             input logic [SumW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  task automatic flag(input string what, input int unsigned want, input int unsigned got);
    fail_count++;
    if (fail_count <= 10)
      $display("diamond_max_path_sum_check: %s: expected %0d, got %0d", what, want, got);
  endtask

  // Advances the forward pass by one cell and queues the path sum when the grid ends.
  task automatic fold_cell(input logic [ValW-1:0] v);
    int unsigned     n;
    int unsigned     r;
    int unsigned     c;
    int unsigned     len;
    logic [SumW-1:0] m;
    logic [SumW-1:0] old;
    logic [SumW-1:0] s;
    if (grid_size == 0) n = 1;
    else if (grid_size > MaxSize) n = MaxSize;
    else n = grid_size;
    r = row_idx;
    c = col_idx;
    if (c >= n) c = n - 1;
    if (r == 0) begin
      m = '0;
    end else if (r < n) begin
      // Upper half: the sources are columns c-1 and c of a row with r cells.
      old = (c < r) ? best_row[c] : '0;
      if (c > 0 && c < r) m = larger(left_sum, old);
      else if (c > 0) m = left_sum;
      else m = old;
      left_sum = old;
    end else begin
      // Lower half: columns c and c+1 always lie inside the wider row above.
      m = larger(best_row[c], (c + 1 < MaxSize) ? best_row[c + 1] : '0);
    end
    s = sat_sum(SumW'(v), m);
    best_row[c] = s;
    len = (r < n) ? r + 1 : 2 * n - 1 - r;
    if (c + 1 < len) begin
      col_idx = c + 1;
    end else begin
      col_idx = 0;
      if (r + 1 >= 2 * n - 1) begin
        row_idx = 0;
        left_sum = '0;
        sums_due.push_back(s);
      end else begin
        row_idx = r + 1;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxSize; i++) best_row[i] = '0;
      left_sum = '0;
      row_idx = 0;
      col_idx = 0;
      grid_size = CfgW'(1);
      sums_due.delete();
      fail_count = 0;
      sums_pending = 0;
    end else begin
      if (psel && penable && pready && paddr[2] == RegGridSize) begin
        if (pwrite) begin
          // A size write abandons whatever grid is in progress.
          grid_size = pwdata[CfgW-1:0];
          row_idx = 0;
          col_idx = 0;
          left_sum = '0;
        end else if (prdata[CfgW-1:0] != grid_size) begin
          flag("grid_size read back", grid_size, prdata[CfgW-1:0]);
        end
      end
      // Results leave at the earliest in the cycle after the last cell, so the
      // oldest one is checked before this edge's cell is folded in.
      if (out_valid_o && !out_stall_i) begin
        if (sums_due.size() == 0) flag("result with no finished grid", 0, max_path_sum_o);
        else if (sums_due[0] != max_path_sum_o) flag("max_path_sum", sums_due[0], max_path_sum_o);
        if (sums_due.size() != 0) void'(sums_due.pop_front());
      end
      if (in_valid_i && !in_stall_o) fold_cell(cell_value_i);
      sums_pending = sums_due.size();
    end
  end

endmodule

// ===== sim/diamond_max_path_sum_test.sv =====
// Testbench top that drives cells and size writes into diamond_max_path_sum and reports the verdict.
module diamond_max_path_sum_test;
  import dmps_pkg::*;

  // Byte addresses on the register port: the size register, and one that
  // decodes to a register that does not exist and must be ignored.
  localparam logic [AddrW-1:0] GridSizeAddr = 3'd0;
  localparam logic [AddrW-1:0] UnmappedAddr = 3'd4;

  localparam int RandomCells  = 950;
  localparam int WideCells    = 150;
  localparam int SettleCycles = 8;
  localparam int CycleLimit   = 2_000_000;

  typedef enum int {GapNone, GapShort, GapLong} gap_mode_e;
  typedef enum int {StallNone, StallSparse, StallPattern, StallHeavy} stall_mode_e;
  typedef enum int {ValMixed, ValTop, ValBounded} val_kind_e;

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic [ValW-1:0]  cell_value_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [SumW-1:0]  max_path_sum_o;
  logic             out_valid_o;
  logic             out_stall_i;

  int          fail_count;
  int          sums_pending;
  int          cycles;
  int          burst_left;
  int          hold_cycles;
  gap_mode_e   gap_mode;
  stall_mode_e stall_mode;

  diamond_max_path_sum dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .cell_value_i   (cell_value_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .max_path_sum_o (max_path_sum_o),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i)
  );

  diamond_max_path_sum_check path_sum_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .cell_value_i   (cell_value_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .max_path_sum_o (max_path_sum_o),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .fail_count     (fail_count),
    .sums_pending   (sums_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // The watchdog ends a run that hangs; a healthy run finishes long before.
  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("[diamond_max_path_sum] ERROR");
    $finish;
  end

  // The result side stalls on a pattern of its own. A hold request makes it
  // stall without a break for that many cycles, counted down here, so that a
  // finished result sits in the block while the sender keeps offering cells.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall_i <= 1'b1;
      end else begin
        case (stall_mode)
          StallNone:    out_stall_i <= 1'b0;
          StallSparse:  out_stall_i <= ($urandom_range(0, 3) == 0);
          StallPattern: out_stall_i <= ((cycles % 7) < 3);
          default:      out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  function automatic logic [ValW-1:0] draw_cell(input val_kind_e kind);
    case (kind)
      ValTop:     return '1;
      ValBounded: return ValW'($urandom_range(0, 32768));
      default: begin
        case ($urandom_range(0, 9))
          0:       return '0;
          1:       return '1;
          2:       return 16'h8000;
          3:       return ValW'($urandom_range(0, 15));
          default: return ValW'($urandom);
        endcase
      end
    endcase
  endfunction

  // Offers one cell and returns at the rising edge where the transfer happens.
  // Bursts of random length are separated by gaps whose size depends on the
  // current gap mode. The stall is looked at on the falling edge, where both
  // sides have settled.
  task automatic put_cell(input logic [ValW-1:0] v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      case (gap_mode)
        GapNone:  gap = 0;
        GapShort: gap = $urandom_range(0, 3);
        default:  gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(1, 5);
      endcase
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    cell_value_i <= v;
    in_valid_i   <= 1'b1;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
  endtask

  task automatic send_cells(input int count, input val_kind_e kind);
    for (int i = 0; i < count; i++) put_cell(draw_cell(kind));
  endtask

  // One register access: a setup cycle, then an access cycle that completes
  // at the edge where pready is high.
  task automatic reg_access(input logic wr, input logic [AddrW-1:0] a,
                            input logic [DataW-1:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Stops offering cells until every predicted result has been taken, then
  // lets the block settle. Cells of an unfinished grid leave nothing behind,
  // so the settle time also covers a grid that is left half done.
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(negedge clk_i); while (sums_pending != 0);
    @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes the size register with random upper data bits, which the register
  // drops, and reads it back for the checker. Returns the size in effect.
  task automatic set_grid_size(input logic [CfgW-1:0] n, output int eff);
    drain();
    reg_access(1'b1, GridSizeAddr, {(DataW - CfgW)'($urandom), n});
    reg_access(1'b0, GridSizeAddr, '0);
    if (n == 0) eff = 1;
    else if (n > MaxSize) eff = MaxSize;
    else eff = n;
  endtask

  // A write to the unmapped address must change nothing, not even the
  // position inside a grid that is in progress.
  task automatic poke_unmapped();
    drain();
    reg_access(1'b1, UnmappedAddr, DataW'($urandom));
    reg_access(1'b0, GridSizeAddr, '0);
  endtask

  initial begin
    int eff;
    int sent;
    int grids;
    int cells;
    int part;
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    cell_value_i = '0;
    in_valid_i   = 1'b0;
    burst_left   = 0;
    hold_cycles  = 0;
    gap_mode     = GapShort;
    stall_mode   = StallSparse;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // The size after reset is one, so every cell is a whole grid.
    put_cell(16'hFFFF);
    put_cell(16'h0000);

    // A size of zero behaves like a size of one.
    set_grid_size(8'd0, eff);
    put_cell(16'h8000);

    set_grid_size(8'd2, eff);
    put_cell(16'h0001);
    put_cell(16'hFFFF);
    put_cell(16'h0000);
    put_cell(16'h7FFF);

    set_grid_size(8'd3, eff);
    put_cell(16'h8000);
    put_cell(16'h0001);
    put_cell(16'hFFFF);
    put_cell(16'h0000);
    put_cell(16'h1234);
    put_cell(16'hFFFE);
    put_cell(16'h0002);
    put_cell(16'h8000);
    put_cell(16'hFFFF);

    // A write to a register that does not exist, made in the middle of a
    // grid, must neither change the size nor restart the grid.
    send_cells(4, ValMixed);
    poke_unmapped();
    send_cells(5, ValMixed);

    // Rewriting the size in the middle of a grid drops that grid without a
    // result; the next grid starts at the top cell.
    send_cells(5, ValMixed);
    set_grid_size(8'd2, eff);
    send_cells(4, ValMixed);

    // Long hold on the result side with one-cell grids: the first result sits
    // in the block, the next cell is held off, and the sender keeps offering.
    set_grid_size(8'd1, eff);
    gap_mode    = GapNone;
    stall_mode  = StallNone;
    hold_cycles = 300;
    send_cells(40, ValMixed);

    // The widest grid runs through its first rows and is then abandoned by
    // the next size write.
    gap_mode   = GapShort;
    stall_mode = StallSparse;
    set_grid_size(8'd128, eff);
    send_cells(WideCells, ValMixed);

    // A size above the largest is kept in the register and read back as
    // written; its first rows run and are abandoned as well.
    gap_mode   = GapNone;
    stall_mode = StallPattern;
    set_grid_size(8'd255, eff);
    send_cells(WideCells, ValBounded);

    // Random phases: mostly small grids sent whole, now and then a grid cut
    // short by the next size write or broken up by an unmapped write.
    sent = 0;
    while (sent < RandomCells) begin
      case ($urandom_range(0, 19))
        0:       set_grid_size(8'd0, eff);
        1:       set_grid_size(8'd1, eff);
        2, 3, 4: set_grid_size(CfgW'($urandom_range(6, 12)), eff);
        5:       set_grid_size(CfgW'($urandom_range(13, 22)), eff);
        default: set_grid_size(CfgW'($urandom_range(2, 5)), eff);
      endcase
      gap_mode   = gap_mode_e'($urandom_range(0, 2));
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      if ($urandom_range(0, 9) == 0) hold_cycles = $urandom_range(100, 400);
      grids = $urandom_range(1, 4);
      for (int g = 0; g < grids; g++) begin
        cells = eff * eff;
        if (cells > 1 && $urandom_range(0, 9) == 0) begin
          part = $urandom_range(1, cells - 1);
          send_cells(part, ValMixed);
          poke_unmapped();
          send_cells(cells - part, ValMixed);
        end else if (cells > 1 && g == grids - 1 && $urandom_range(0, 5) == 0) begin
          // Left unfinished; the size write of the next phase abandons it.
          cells = $urandom_range(1, cells - 1);
          send_cells(cells, ValMixed);
        end else begin
          send_cells(cells, ValMixed);
        end
        sent += cells;
      end
    end

    drain();
    if (fail_count == 0 && sums_pending == 0) begin
      $display("[diamond_max_path_sum] OK");
    end else begin
      $display("[diamond_max_path_sum] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/dmps_pkg.sv
src/dmps_cell.sv
src/dmps_chain.sv
src/diamond_max_path_sum.sv
sim/diamond_max_path_sum_check.sv
sim/diamond_max_path_sum_test.sv
